### rtl/uvsph_pkg.sv
package uvsph_pkg;

  localparam int CordicSteps = 30;
  localparam int IdxW = 17;
  localparam int PosW = 17;
  localparam int NrmW = 16;
  localparam int TexW = 17;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic [15:0] RadiusReset = 16'd9216;
  localparam logic [7:0] SlicesReset = 8'd16;

  typedef enum logic [0:0] {
    KIND_VERTEX = 1'b0,
    KIND_TRI    = 1'b1
  } kind_t;

  typedef enum logic [0:0] {
    REG_SLICES = 1'b0,
    REG_RADIUS = 1'b1
  } reg_idx_t;

  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] t;
    case (i)
      5'd0: t = 32'h20000000;
      5'd1: t = 32'h12E4051E;
      5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4;
      5'd4: t = 32'h028B0D43;
      5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;
      5'd7: t = 32'h00517C55;
      5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/uvsph_stream_if.sv
interface uvsph_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/uvsph_front.sv
module uvsph_front
  import uvsph_pkg::*;
#(
  parameter int MAX_SLICES = 128,
  parameter int ANGLE_BITS = 16,
  parameter int SW = 8,
  parameter int QW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    slices_cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [6:0]    grid_row,
  input  logic [8:0]    grid_col,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [QW-1:0] q_data
);
  // clamps the cell, then divides for phases and uv by restoring division
  localparam int NumW = (ANGLE_BITS + 11 > 27) ? ANGLE_BITS + 11 : 27;
  localparam int DivSteps = NumW;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_OUT} fstate_t;

  fstate_t state_r;
  logic [SW-1:0] s_r;
  logic [6:0] row_r;
  logic [8:0] col_r;
  logic [5:0] step_r;
  logic [1:0] which_r;
  logic [NumW-1:0] num_r, quo_r;
  logic [NumW+1:0] rem_r, den_r;
  logic [ANGLE_BITS-1:0] pa_r, pb_r;
  logic [TexW-1:0] tu_r, tv_r;

  logic [SW-1:0] s_eff;
  logic [SW:0] w_eff;
  logic [6:0] row_c;
  logic [8:0] col_c;
  logic [NumW+1:0] rem_sh;

  always_comb begin
    if ({1'b0, slices_cfg} < 9'd2) s_eff = SW'(2);
    else if (32'(slices_cfg) > MAX_SLICES) s_eff = SW'(MAX_SLICES);
    else s_eff = SW'(slices_cfg);
    w_eff = {s_eff, 1'b0};
    row_c = (32'(grid_row) > 32'(s_eff) - 1) ? 7'(s_eff - 1'b1) : grid_row;
    col_c = (32'(grid_col) > 32'(w_eff)) ? 9'(w_eff) : grid_col;
    rem_sh = {rem_r[NumW:0], num_r[NumW-1]};
  end

  function automatic logic [NumW-1:0] numer(input logic [1:0] k, input logic [6:0] r,
                                            input logic [8:0] c, input logic [SW-1:0] s);
    logic [NumW-1:0] v;
    logic [SW:0] w;
    w = {s, 1'b0};
    case (k)
      2'd0: v = (NumW'(r) << ANGLE_BITS) + NumW'(s - 1'b1);
      2'd1: v = (NumW'(c) << ANGLE_BITS) + NumW'(s);
      2'd2: v = (NumW'(w - c) << 17) + NumW'(w);
      default: v = (NumW'(r) << 17) + NumW'(s - 1'b1);
    endcase
    return v;
  endfunction

  function automatic logic [NumW+1:0] denom(input logic [1:0] k, input logic [SW-1:0] s);
    logic [NumW+1:0] v;
    case (k)
      2'd1: v = (NumW+2)'(s) << 1;
      2'd2: v = (NumW+2)'(s) << 2;
      default: v = (NumW+2)'(s - 1'b1) << 1;
    endcase
    return v;
  endfunction

  assign in_ready = (state_r == F_IDLE);
  assign q_valid = (state_r == F_OUT);
  assign q_data = QW'({row_r, col_r, pa_r, pb_r, tu_r, tv_r} >> 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            s_r <= s_eff;
            row_r <= row_c;
            col_r <= col_c;
            which_r <= 2'd0;
            step_r <= '0;
            num_r <= numer(2'd0, row_c, col_c, s_eff);
            den_r <= denom(2'd0, s_eff);
            rem_r <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          if (step_r == 6'(DivSteps - 1)) begin
            step_r <= '0;
            which_r <= which_r + 2'd1;
            num_r <= numer(which_r + 2'd1, row_r, col_r, s_r);
            den_r <= denom(which_r + 2'd1, s_r);
            rem_r <= '0;
            if (which_r == 2'd3) state_r <= F_OUT;
          end else begin
            num_r <= num_r << 1;
            if (rem_sh >= den_r) begin
              rem_r <= rem_sh - den_r;
              quo_r <= {quo_r[NumW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[NumW-2:0], 1'b0};
            end
            step_r <= step_r + 6'd1;
          end
        end
        F_OUT: begin
          if (q_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  logic [NumW-1:0] quo_fin;
  assign quo_fin = {quo_r[NumW-2:0], (rem_sh >= den_r)};

  always_ff @(posedge clk) begin
    if (state_r == F_DIV && step_r == 6'(DivSteps - 1)) begin
      case (which_r)
        2'd0: pa_r <= ANGLE_BITS'(quo_fin);
        2'd1: pb_r <= ANGLE_BITS'(quo_fin);
        2'd2: tu_r <= TexW'(quo_fin);
        default: tv_r <= TexW'(quo_fin);
      endcase
    end
  end

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV) |-> (step_r < 6'(DivSteps))) else $error("step overrun");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_ready) |=> q_valid) else $error("queue word dropped");
  a_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> (state_r == F_DIV)) else $error("no start");
  a_row: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (32'(row_r) <= 32'(s_r) - 32'd1)) else $error("row not clamped");

endmodule

### rtl/uvsph_back.sv
module uvsph_back
  import uvsph_pkg::*;
#(
  parameter int SW = 8,
  parameter int QW = 40,
  parameter int ANGLE_BITS = 16,
  parameter int OW = 135
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] s_eff,
  input  logic [15:0]   radius,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_data
);
  typedef enum logic [2:0] {B_IDLE, B_COR, B_MUL, B_POS, B_EMIT} bstate_t;

  bstate_t state_r;
  logic [6:0] row_r;
  logic [8:0] col_r;
  logic [TexW-1:0] tu_r, tv_r;
  logic [1:0] quada_r, quadb_r;
  logic signed [33:0] xa_r, ya_r, za_r, xb_r, yb_r, zb_r;
  logic [4:0] it_r;
  logic signed [33:0] sa_r, ca_r, sb_r, cb_r;
  logic signed [33:0] u_r [3];
  logic [1:0] k_r;
  logic signed [PosW-1:0] p_r [3];
  logic signed [NrmW-1:0] n_r [3];
  logic [1:0] emit_r;

  logic [6:0] qrow;
  logic [8:0] qcol;
  logic [ANGLE_BITS-1:0] qpa, qpb;
  logic [TexW-1:0] qtu, qtv;
  assign {qrow, qcol, qpa, qpb, qtu, qtv} = q_data;

  logic [31:0] pha, phb;
  assign pha = 32'(qpa) << (32 - ANGLE_BITS);
  assign phb = 32'(qpb) << (32 - ANGLE_BITS);

  logic signed [33:0] atn;
  assign atn = 34'(atan_turn(it_r));

  function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
    return (v + 68'sd536870912) >>> 30;
  endfunction

  logic signed [67:0] prod;
  logic signed [33:0] ma, mb;
  always_comb begin
    case (k_r)
      2'd0: begin ma = sa_r; mb = cb_r; end
      default: begin ma = sa_r; mb = sb_r; end
    endcase
    prod = 68'(ma) * 68'(mb);
  end

  logic signed [67:0] pprod, nrm;
  assign pprod = rnd30(68'(u_r[k_r]) * 68'($signed({1'b0, radius})));
  assign nrm = (68'(u_r[k_r]) + 68'sd32768) >>> 16;

  logic [SW+1:0] wn;
  logic [16:0] cur, nxt, jn, ccol;
  logic last_row;
  always_comb begin
    wn = (SW+2)'({s_eff, 1'b0}) + (SW+2)'(1);
    cur = 17'(row_r * wn);
    nxt = 17'((row_r + 8'd1) * wn);
    jn = (10'(col_r) == 10'({s_eff, 1'b0})) ? 17'd0 : 17'(col_r) + 17'd1;
    ccol = 17'(col_r);
    last_row = (8'(row_r) >= 8'(s_eff - 1'b1));
  end

  always_comb begin
    case (emit_r)
      2'd0: out_data = {KIND_VERTEX, last_row, p_r[0], p_r[1], p_r[2],
                        n_r[0], n_r[1], n_r[2], tu_r, tv_r};
      2'd1: out_data = {KIND_TRI, 1'b0, nxt + jn, cur + jn, cur + ccol,
                        48'd0, 34'd0};
      default: out_data = {KIND_TRI, 1'b1, cur + ccol, nxt + ccol, nxt + jn,
                           48'd0, 34'd0};
    endcase
  end

  assign q_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            row_r <= qrow; col_r <= qcol; tu_r <= qtu; tv_r <= qtv;
            quada_r <= pha[31:30]; quadb_r <= phb[31:30];
            xa_r <= 34'(CordicGain); ya_r <= '0; za_r <= 34'({2'b0, pha[29:0]});
            xb_r <= 34'(CordicGain); yb_r <= '0; zb_r <= 34'({2'b0, phb[29:0]});
            it_r <= '0;
            state_r <= B_COR;
          end
        end
        B_COR: begin
          if (!za_r[33]) begin
            xa_r <= xa_r - (ya_r >>> it_r); ya_r <= ya_r + (xa_r >>> it_r);
            za_r <= za_r - atn;
          end else begin
            xa_r <= xa_r + (ya_r >>> it_r); ya_r <= ya_r - (xa_r >>> it_r);
            za_r <= za_r + atn;
          end
          if (!zb_r[33]) begin
            xb_r <= xb_r - (yb_r >>> it_r); yb_r <= yb_r + (xb_r >>> it_r);
            zb_r <= zb_r - atn;
          end else begin
            xb_r <= xb_r + (yb_r >>> it_r); yb_r <= yb_r - (xb_r >>> it_r);
            zb_r <= zb_r + atn;
          end
          if (it_r == 5'(CordicSteps - 1)) begin
            it_r <= '0;
            state_r <= B_MUL;
          end else begin
            it_r <= it_r + 5'd1;
          end
        end
        B_MUL: begin
          case (quada_r)
            2'd0: begin ca_r <= xa_r; sa_r <= ya_r; end
            2'd1: begin ca_r <= -ya_r; sa_r <= xa_r; end
            2'd2: begin ca_r <= -xa_r; sa_r <= -ya_r; end
            default: begin ca_r <= ya_r; sa_r <= -xa_r; end
          endcase
          case (quadb_r)
            2'd0: begin cb_r <= xb_r; sb_r <= yb_r; end
            2'd1: begin cb_r <= -yb_r; sb_r <= xb_r; end
            2'd2: begin cb_r <= -xb_r; sb_r <= -yb_r; end
            default: begin cb_r <= yb_r; sb_r <= -xb_r; end
          endcase
          k_r <= '0;
          state_r <= B_POS;
        end
        B_POS: begin
          // it 0, k 0..1: products into unit vector, u[2] from cos a; it 1, k 0..2: scale and clamp
          if (it_r == 5'd0) begin
            u_r[k_r] <= 34'(rnd30(prod));
            if (k_r == 2'd1) begin
              u_r[2] <= ca_r;
              k_r <= '0;
              it_r <= 5'd1;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end else begin
            if (pprod < -68'sd65536) p_r[k_r] <= -17'sd65536;
            else if (pprod > 68'sd65535) p_r[k_r] <= 17'sd65535;
            else p_r[k_r] <= 17'(pprod);
            if (nrm < -68'sd16384) n_r[k_r] <= -16'sd16384;
            else if (nrm > 68'sd16384) n_r[k_r] <= 16'sd16384;
            else n_r[k_r] <= 16'(nrm);
            if (k_r == 2'd2) begin
              it_r <= '0;
              emit_r <= '0;
              state_r <= B_EMIT;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        B_EMIT: begin
          if (out_ready) begin
            if (emit_r == 2'd2 || (emit_r == 2'd0 && last_row)) begin
              state_r <= B_IDLE;
            end else begin
              emit_r <= emit_r + 2'd1;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT) |-> (emit_r != 2'd3)) else $error("bad emit index");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(emit_r))) else $error("word lost");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> (state_r == B_COR)) else $error("no cordic start");

endmodule

### rtl/uv_sphere_grid_tessellator_unit.sv
// channel | dir | fields
// in_     | in  | grid_row, grid_col
// out_    | out | kind, last, word_a/b/c, normal_x/y/z, tex_u, tex_v
// cfg_    | in  | APB: slice_count @0x0, sphere_radius @0x4
// Front: accept, 4 serial divisions of 27 steps each (ANGLE_BITS+11, at
// least 27), then hand-off of the result word to the queue.
// Back: accept, 30 CORDIC steps, quadrant fix, 5 scale steps, then 1 or 3
// output words.
// A one-word queue between them lets the front divide the next cell while the
// back works; the front's divisions set the throughput unless the output stalls.
// Synchronous active-low reset clears control and sets config to its defaults; stalls hold words.
module uv_sphere_grid_tessellator_unit
  import uvsph_pkg::*;
#(
  parameter int MAX_SLICES = 128,
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  uvsph_stream_if.sink   in_if,
  uvsph_stream_if.source out_if,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int QW = 7 + 9 + 2 * ANGLE_BITS + 2 * TexW;
  localparam int OW = 2 + 3 * PosW + 3 * NrmW + 2 * TexW;

  logic [7:0] slices_r;
  logic [15:0] radius_r;
  logic [7:0] s_eff;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= SlicesReset;
      radius_r <= RadiusReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_SLICES) slices_r <= cfg_pwdata[7:0];
      else radius_r <= cfg_pwdata[15:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_SLICES) ? {24'd0, slices_r} : {16'd0, radius_r};

  always_comb begin
    if (slices_r < 8'd2) s_eff = 8'd2;
    else if (32'(slices_r) > MAX_SLICES) s_eff = 8'(MAX_SLICES);
    else s_eff = slices_r;
  end

  logic f_valid, f_ready, b_valid, b_ready, qf_r;
  logic [QW-1:0] f_data, q_r;

  uvsph_front #(.MAX_SLICES(MAX_SLICES), .ANGLE_BITS(ANGLE_BITS), .SW(8), .QW(QW)) u_front (
    .clk, .rst_n, .slices_cfg(slices_r),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .grid_row(in_if.data[15:9]), .grid_col(in_if.data[8:0]),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data));

  assign f_ready = !qf_r;
  assign b_valid = qf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qf_r <= 1'b0;
    end else begin
      if (f_valid && f_ready) begin
        qf_r <= 1'b1;
        q_r <= f_data;
      end else if (b_valid && b_ready) begin
        qf_r <= 1'b0;
      end
    end
  end

  uvsph_back #(.SW(8), .QW(QW), .ANGLE_BITS(ANGLE_BITS), .OW(OW)) u_back (
    .clk, .rst_n, .s_eff, .radius(radius_r),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(q_r),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data));

endmodule
